// ----- design/dchf_pkg.sv -----
// Shared types and constants of the deduplicating command history store.
`timescale 1ns / 1ps
`default_nettype none

package dchf_pkg;

  // Default sizes of the store.
  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int COMMAND_BYTES_DEF = 256;

  // Operation code of an input item.
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // Status code of a result item.
  typedef enum logic [2:0] {
    STS_STAGED    = 3'd0,
    STS_APPENDED  = 3'd1,
    STS_EVICTED   = 3'd2,
    STS_DUPLICATE = 3'd3,
    STS_EMPTY     = 3'd4,
    STS_READ      = 3'd5
  } status_e;

  // Sequencer states of the core.
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_READ      = 3'd1,
    ST_SCAN_LEN  = 3'd2,
    ST_SCAN_LCHK = 3'd3,
    ST_SCAN_CMP  = 3'd4,
    ST_COPY      = 3'd5,
    ST_COPY_LAST = 3'd6
  } state_e;

endpackage

`default_nettype wire

// ----- design/dedup_command_history_fifo_core.sv -----
// Deduplicating command history store: sequencer, staging, entry and length memories.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Input items arrive on in_valid_i / in_stall_o. An add item (operation 0) brings one
// command byte, and a zero byte ends the command. A read item (operation 1) asks for
// one byte of a stored entry, where entry 0 is the oldest. Every input item gives
// exactly one result item on out_valid_o / out_stall_i, in order.
// A nonzero add byte gives its result in the cycle after acceptance, and a new item can
// follow at once unless the receiver stalls. A read at an invalid index and an empty
// command are answered from the idle state directly. A read of a stored entry goes
// through the registered read port of the length and entry memories and ST_READ. A
// terminator walks the stored entries until it finds a duplicate: each passes ST_SCAN_LEN
// and ST_SCAN_LCHK, and one of equal length is compared byte by byte in ST_SCAN_CMP. If
// none matches, the append copies the staged bytes one per cycle through the single entry write port.
// The core works on one item at a time and holds in_stall_o high while busy.
// Reset clears the entry count, the ring pointer, the staged length and the overflow
// flag; the memories need no clearing pass, as only written entries are ever read.
// While the receiver stalls, the result register holds its item and no new item is
// taken until that item leaves.
module dedup_command_history_fifo_core #(
  parameter int HISTORY_DEPTH = dchf_pkg::HISTORY_DEPTH_DEF,
  parameter int COMMAND_BYTES = dchf_pkg::COMMAND_BYTES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       operation_i,
  input  wire logic [7:0] cmd_byte_i,
  input  wire logic [7:0] entry_index_i,
  input  wire logic [7:0] char_position_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      status_o,
  output logic [7:0]      read_byte_o,
  output logic            entry_valid_o,
  output logic [4:0]      entry_count_o,
  output logic            truncated_o
);

  localparam int HW        = $clog2(HISTORY_DEPTH);
  localparam int NW        = $clog2(HISTORY_DEPTH + 1);
  localparam int CW        = $clog2(COMMAND_BYTES);
  localparam int LW        = $clog2(COMMAND_BYTES + 1);
  localparam int ENT_DEPTH = HISTORY_DEPTH * COMMAND_BYTES;
  localparam int AW        = $clog2(ENT_DEPTH);
  localparam int ICW       = (NW > 8) ? NW : 8;
  localparam int PCW       = (LW > 8) ? LW : 8;

  // Ring slot of a logical entry position.
  function automatic logic [HW-1:0] slot_of(input logic [HW-1:0] base,
                                            input logic [HW-1:0] pos);
    logic [HW:0] s;
    s = {1'b0, base} + {1'b0, pos};
    if (s >= (HW+1)'(HISTORY_DEPTH)) s = s - (HW+1)'(HISTORY_DEPTH);
    return s[HW-1:0];
  endfunction

  // Flat address of a byte within a slot of the entry memory.
  function automatic logic [AW-1:0] ent_addr(input logic [HW-1:0] slot,
                                             input logic [CW-1:0] pos);
    return AW'(slot) * AW'(COMMAND_BYTES) + AW'(pos);
  endfunction

  dchf_pkg::state_e  state_q, state_d;
  logic              out_valid_q;
  logic [LW-1:0]     stg_len_q, stg_len_d;
  logic              flag_q, flag_d;
  logic [HW-1:0]     oldest_q, oldest_d;
  logic [NW-1:0]     count_q, count_d;

  logic [NW-1:0]     i_q, i_d;
  logic [CW-1:0]     j_q, j_d;
  logic [HW-1:0]     slot_q, slot_d;
  logic [7:0]        pos_q, pos_d;
  logic [CW-1:0]     cp_j_q, cp_j_d;
  logic              cp_v_q, cp_v_d;

  dchf_pkg::status_e status_q, res_status;
  logic [7:0]        read_byte_q, res_byte;
  logic              entry_valid_q, res_valid;
  logic [4:0]        entry_count_q;
  logic              truncated_q, res_trunc;
  logic              res_load;

  logic              stg_we;
  logic [CW-1:0]     stg_waddr, stg_raddr;
  logic [7:0]        stg_rdata_q;
  logic              ent_we;
  logic [AW-1:0]     ent_waddr, ent_raddr;
  logic [7:0]        ent_rdata_q;
  logic              len_we;
  logic [HW-1:0]     len_waddr, len_raddr;
  logic [LW-1:0]     len_rdata_q;

  logic [7:0]        stg_mem [COMMAND_BYTES];
  logic [7:0]        ent_mem [ENT_DEPTH];
  logic [LW-1:0]     len_mem [HISTORY_DEPTH];

  logic              in_acc;
  logic              idx_ok;
  logic              len_full;
  logic              last_j;
  logic              byte_eq;
  logic [CW-1:0]     j_next;
  logic [HW-1:0]     rd_slot;

  // Handshake: one item at a time, and only once the result register can take a result.
  assign in_stall_o = (state_q != dchf_pkg::ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Shared conditions.
  assign idx_ok   = ICW'(entry_index_i) < ICW'(count_q);
  assign len_full = (stg_len_q == LW'(COMMAND_BYTES));
  assign last_j   = (LW'(j_q) == (stg_len_q - LW'(1)));
  assign byte_eq  = (ent_rdata_q == stg_rdata_q);
  assign j_next   = j_q + CW'(1);
  assign rd_slot  = slot_of(oldest_q, HW'(entry_index_i));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dchf_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (operation_i == dchf_pkg::OP_READ) begin
            if (idx_ok) state_d = dchf_pkg::ST_READ;
          end else if (cmd_byte_i == 8'd0 && stg_len_q != '0) begin
            state_d = dchf_pkg::ST_SCAN_LEN;
          end
        end
      end
      dchf_pkg::ST_READ: state_d = dchf_pkg::ST_IDLE;
      dchf_pkg::ST_SCAN_LEN: begin
        state_d = (i_q == count_q) ? dchf_pkg::ST_COPY : dchf_pkg::ST_SCAN_LCHK;
      end
      dchf_pkg::ST_SCAN_LCHK: begin
        state_d = (len_rdata_q == stg_len_q) ? dchf_pkg::ST_SCAN_CMP
                                             : dchf_pkg::ST_SCAN_LEN;
      end
      dchf_pkg::ST_SCAN_CMP: begin
        if (!byte_eq) state_d = dchf_pkg::ST_SCAN_LEN;
        else if (last_j) state_d = dchf_pkg::ST_IDLE;
      end
      dchf_pkg::ST_COPY: begin
        if (last_j) state_d = dchf_pkg::ST_COPY_LAST;
      end
      dchf_pkg::ST_COPY_LAST: state_d = dchf_pkg::ST_IDLE;
      default: state_d = dchf_pkg::ST_IDLE;
    endcase
  end

  // Memory accesses, register updates and result values for each state.
  always_comb begin
    stg_we     = 1'b0;
    stg_waddr  = stg_len_q[CW-1:0];
    stg_raddr  = j_q;
    ent_we     = 1'b0;
    ent_waddr  = ent_addr(slot_q, cp_j_q);
    ent_raddr  = ent_addr(slot_q, j_q);
    len_we     = 1'b0;
    len_waddr  = slot_q;
    len_raddr  = slot_q;
    stg_len_d  = stg_len_q;
    flag_d     = flag_q;
    oldest_d   = oldest_q;
    count_d    = count_q;
    i_d        = i_q;
    j_d        = j_q;
    slot_d     = slot_q;
    pos_d      = pos_q;
    cp_j_d     = cp_j_q;
    cp_v_d     = cp_v_q;
    res_load   = 1'b0;
    res_status = dchf_pkg::STS_STAGED;
    res_byte   = 8'd0;
    res_valid  = 1'b0;
    res_trunc  = flag_q;
    case (state_q)
      dchf_pkg::ST_IDLE: begin
        // A read looks up its slot right away, so the data arrive next cycle.
        ent_raddr = ent_addr(rd_slot, CW'(char_position_i));
        len_raddr = rd_slot;
        pos_d     = char_position_i;
        i_d       = '0;
        if (in_acc) begin
          if (operation_i == dchf_pkg::OP_READ) begin
            if (!idx_ok) begin
              res_load   = 1'b1;
              res_status = dchf_pkg::STS_READ;
            end
          end else if (cmd_byte_i != 8'd0) begin
            res_load   = 1'b1;
            res_status = dchf_pkg::STS_STAGED;
            res_trunc  = flag_q || len_full;
            if (len_full) begin
              flag_d = 1'b1;
            end else begin
              stg_we    = 1'b1;
              stg_len_d = stg_len_q + LW'(1);
            end
          end else if (stg_len_q == '0) begin
            res_load   = 1'b1;
            res_status = dchf_pkg::STS_EMPTY;
            flag_d     = 1'b0;
          end
        end
      end
      dchf_pkg::ST_READ: begin
        res_load   = 1'b1;
        res_status = dchf_pkg::STS_READ;
        res_valid  = 1'b1;
        if (PCW'(pos_q) < PCW'(len_rdata_q)) res_byte = ent_rdata_q;
      end
      dchf_pkg::ST_SCAN_LEN: begin
        // Fetch the length of the next entry, or pick the slot to write.
        len_raddr = slot_of(oldest_q, i_q[HW-1:0]);
        slot_d    = slot_of(oldest_q, i_q[HW-1:0]);
        if (i_q == count_q) begin
          j_d    = '0;
          cp_v_d = 1'b0;
          if (ICW'(count_q) < ICW'(HISTORY_DEPTH)) begin
            slot_d = slot_of(oldest_q, count_q[HW-1:0]);
          end else begin
            slot_d = oldest_q;
          end
        end
      end
      dchf_pkg::ST_SCAN_LCHK: begin
        // Equal lengths start a byte compare from position zero.
        j_d       = '0;
        stg_raddr = '0;
        ent_raddr = ent_addr(slot_q, '0);
        if (len_rdata_q != stg_len_q) i_d = i_q + NW'(1);
      end
      dchf_pkg::ST_SCAN_CMP: begin
        stg_raddr = j_next;
        ent_raddr = ent_addr(slot_q, j_next);
        j_d       = j_next;
        if (!byte_eq) begin
          i_d = i_q + NW'(1);
        end else if (last_j) begin
          res_load   = 1'b1;
          res_status = dchf_pkg::STS_DUPLICATE;
          stg_len_d  = '0;
          flag_d     = 1'b0;
        end
      end
      dchf_pkg::ST_COPY: begin
        // Read one staged byte per cycle and write the previous one.
        stg_raddr = j_q;
        cp_j_d    = j_q;
        cp_v_d    = 1'b1;
        ent_we    = cp_v_q;
        j_d       = j_next;
      end
      dchf_pkg::ST_COPY_LAST: begin
        ent_we    = 1'b1;
        len_we    = 1'b1;
        res_load  = 1'b1;
        stg_len_d = '0;
        flag_d    = 1'b0;
        if (ICW'(count_q) < ICW'(HISTORY_DEPTH)) begin
          count_d    = count_q + NW'(1);
          res_status = dchf_pkg::STS_APPENDED;
        end else begin
          oldest_d   = slot_of(oldest_q, HW'(1));
          res_status = dchf_pkg::STS_EVICTED;
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dchf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      stg_len_q   <= '0;
      flag_q      <= 1'b0;
      oldest_q    <= '0;
      count_q     <= '0;
    end else begin
      state_q   <= state_d;
      stg_len_q <= stg_len_d;
      flag_q    <= flag_d;
      oldest_q  <= oldest_d;
      count_q   <= count_d;
      if (res_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    slot_q <= slot_d;
    pos_q  <= pos_d;
    cp_j_q <= cp_j_d;
    cp_v_q <= cp_v_d;
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q      <= res_status;
      read_byte_q   <= res_byte;
      entry_valid_q <= res_valid;
      entry_count_q <= 5'(count_d);
      truncated_q   <= res_trunc;
    end
  end

  // Staging memory.
  always_ff @(posedge clk_i) begin
    if (stg_we) stg_mem[stg_waddr] <= cmd_byte_i;
    stg_rdata_q <= stg_mem[stg_raddr];
  end

  // Entry byte memory, one slot of COMMAND_BYTES bytes per entry.
  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= stg_rdata_q;
    ent_rdata_q <= ent_mem[ent_raddr];
  end

  // Entry length memory.
  always_ff @(posedge clk_i) begin
    if (len_we) len_mem[len_waddr] <= stg_len_q;
    len_rdata_q <= len_mem[len_raddr];
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_byte_o   = read_byte_q;
  assign entry_valid_o = entry_valid_q;
  assign entry_count_o = entry_count_q;
  assign truncated_o   = truncated_q;

endmodule

`default_nettype wire

// ----- design/dchf_checker.sv -----
// Port-level assertions for the command history core and their bind.
`timescale 1ns / 1ps
`default_nettype none

module dchf_checker #(
  parameter int HISTORY_DEPTH = dchf_pkg::HISTORY_DEPTH_DEF
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [2:0] status_o,
  input wire logic [7:0] read_byte_o,
  input wire logic       entry_valid_o,
  input wire logic [4:0] entry_count_o
);

  // A stalled result item holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(read_byte_o) && $stable(entry_count_o))
    else $error("stalled result item changed");

  // Add results never carry read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != dchf_pkg::STS_READ |-> !entry_valid_o && read_byte_o == 8'd0)
    else $error("add result carries read data");

  // Data can only come from a valid entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_byte_o != 8'd0 |-> entry_valid_o)
    else $error("read byte from an invalid entry");

  // Eviction happens only with a full store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == dchf_pkg::STS_EVICTED |-> entry_count_o == 5'(HISTORY_DEPTH))
    else $error("eviction with a store that is not full");

  // The entry count never exceeds the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(entry_count_o) <= HISTORY_DEPTH)
    else $error("entry count beyond depth");

endmodule

bind dedup_command_history_fifo_core dchf_checker #(
  .HISTORY_DEPTH(HISTORY_DEPTH)
) u_dchf_checker (.*);

`default_nettype wire
